/* hw/rtl/msgpack_token_decoder_defines.svh */
// assertion macros used by the token decoder core
`ifndef MSGPACK_TOKEN_DECODER_DEFINES_SVH
`define MSGPACK_TOKEN_DECODER_DEFINES_SVH

// same-cycle implication, checked on every rising edge outside reset
`define MSGTD_ASSERT_IMP(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("msgtd: same-cycle check failed");

// next-cycle implication, checked on every rising edge outside reset
`define MSGTD_ASSERT_NXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("msgtd: next-cycle check failed");

`endif

/* hw/rtl/msgtd_pkg.sv */
// shared types and token kind codes for the token decoder
package msgtd_pkg;

  // token kinds
  localparam logic [3:0] K_UINT  = 4'd0;
  localparam logic [3:0] K_INT   = 4'd1;
  localparam logic [3:0] K_MAP   = 4'd2;
  localparam logic [3:0] K_ARRAY = 4'd3;
  localparam logic [3:0] K_STR   = 4'd4;
  localparam logic [3:0] K_BIN   = 4'd5;
  localparam logic [3:0] K_NIL   = 4'd6;
  localparam logic [3:0] K_BOOL  = 4'd7;
  localparam logic [3:0] K_F32   = 4'd8;
  localparam logic [3:0] K_F64   = 4'd9;
  localparam logic [3:0] K_BYTE  = 4'd10;
  localparam logic [3:0] K_ERR   = 4'd11;

  // one input request
  typedef struct packed {
    logic [7:0] data_byte;
    logic       buffer_end;
  } in_item_t;

  // one decoded token
  typedef struct packed {
    logic [3:0]  kind;
    logic [63:0] value;
    logic [31:0] length;
    logic        payload_last;
  } tok_t;

endpackage

/* hw/rtl/msgtd_in_reg.sv */
// input register stage holding one byte request ahead of the decoder
module msgtd_in_reg
  import msgtd_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_item_t in_item,
  output logic     s1_valid,
  output in_item_t s1_item,
  input  logic     dn_ready
);

  logic     valid_r, valid_nxt;
  in_item_t item_r;

  // stage frees when empty or when the decoder takes it
  assign in_ready = !valid_r || dn_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (in_valid && in_ready) begin
      valid_nxt = 1'b1;
    end else if (dn_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
  end

  assign s1_valid = valid_r;
  assign s1_item  = item_r;

endmodule

/* hw/rtl/msgtd_core.sv */
// decoder state and single-pass tag, header and payload decode
module msgtd_core
  import msgtd_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     s1_valid,
  input  in_item_t s1_item,
  input  logic     slot_ready,
  output logic     take,
  output logic     tok_valid,
  output tok_t     tok
);

`include "msgpack_token_decoder_defines.svh"

  typedef enum logic [2:0] {
    PH_TAG = 3'b001,
    PH_HDR = 3'b010,
    PH_PAY = 3'b100
  } phase_t;

  // tag codes
  localparam logic [7:0] TAG_NIL   = 8'hc0;
  localparam logic [7:0] TAG_FALSE = 8'hc2;
  localparam logic [7:0] TAG_TRUE  = 8'hc3;
  localparam logic [7:0] TAG_BIN8  = 8'hc4;
  localparam logic [7:0] TAG_BIN16 = 8'hc5;
  localparam logic [7:0] TAG_BIN32 = 8'hc6;
  localparam logic [7:0] TAG_F32   = 8'hca;
  localparam logic [7:0] TAG_F64   = 8'hcb;
  localparam logic [7:0] TAG_U8    = 8'hcc;
  localparam logic [7:0] TAG_U16   = 8'hcd;
  localparam logic [7:0] TAG_U32   = 8'hce;
  localparam logic [7:0] TAG_U64   = 8'hcf;
  localparam logic [7:0] TAG_I8    = 8'hd0;
  localparam logic [7:0] TAG_I16   = 8'hd1;
  localparam logic [7:0] TAG_I32   = 8'hd2;
  localparam logic [7:0] TAG_I64   = 8'hd3;
  localparam logic [7:0] TAG_STR8  = 8'hd9;
  localparam logic [7:0] TAG_STR16 = 8'hda;
  localparam logic [7:0] TAG_STR32 = 8'hdb;
  localparam logic [7:0] TAG_ARR16 = 8'hdc;
  localparam logic [7:0] TAG_ARR32 = 8'hdd;
  localparam logic [7:0] TAG_MAP16 = 8'hde;
  localparam logic [7:0] TAG_MAP32 = 8'hdf;

  // header byte count following a tag, zero for single-byte and unknown tags
  function automatic logic [3:0] hdr_bytes(input logic [7:0] t);
    logic [3:0] n;
    n = 4'd0;
    unique case (t) inside
      TAG_BIN8, TAG_U8, TAG_I8, TAG_STR8:                          n = 4'd1;
      TAG_BIN16, TAG_U16, TAG_I16, TAG_STR16, TAG_ARR16, TAG_MAP16: n = 4'd2;
      TAG_BIN32, TAG_F32, TAG_U32, TAG_I32, TAG_STR32, TAG_ARR32,
      TAG_MAP32:                                                   n = 4'd4;
      TAG_F64, TAG_U64, TAG_I64:                                   n = 4'd8;
      default:                                                     n = 4'd0;
    endcase
    return n;
  endfunction

  phase_t      phase_r, phase_nxt;
  logic [7:0]  tag_r, tag_nxt;
  logic [3:0]  bytes_left_r, bytes_left_nxt;
  logic [63:0] acc_r, acc_nxt;
  logic [31:0] payload_left_r, payload_left_nxt;
  logic        dropping_r, dropping_nxt;

  logic [7:0]  b;
  logic        last_in;
  logic [63:0] acc_sh;
  logic [3:0]  hdr_n;
  logic [31:0] pay_dec;

  assign take    = s1_valid && slot_ready;
  assign b       = s1_item.data_byte;
  assign last_in = s1_item.buffer_end;
  assign acc_sh  = {acc_r[55:0], b};
  assign hdr_n   = hdr_bytes(b);
  assign pay_dec = payload_left_r - 32'd1;

  // next state and token for the request in the input stage
  always_comb begin
    logic        err;
    logic        err_drop;
    logic        start_pay;
    logic [3:0]  start_kind;
    logic [31:0] start_len;

    err        = 1'b0;
    err_drop   = 1'b0;
    start_pay  = 1'b0;
    start_kind = K_STR;
    start_len  = 32'd0;

    phase_nxt        = phase_r;
    tag_nxt          = tag_r;
    bytes_left_nxt   = bytes_left_r;
    acc_nxt          = acc_r;
    payload_left_nxt = payload_left_r;
    dropping_nxt     = dropping_r;
    tok_valid        = 1'b0;
    tok              = '0;

    if (take) begin
      if (dropping_r) begin
        // skip to the end of the buffer
        if (last_in) begin
          dropping_nxt = 1'b0;
        end
        phase_nxt = PH_TAG;
      end else begin
        unique case (phase_r)
          PH_HDR: begin
            acc_nxt        = acc_sh;
            bytes_left_nxt = bytes_left_r - 4'd1;
            if (bytes_left_r == 4'd1) begin
              // header complete
              phase_nxt = PH_TAG;
              tok_valid = 1'b1;
              unique case (tag_r) inside
                TAG_U8, TAG_U16, TAG_U32, TAG_U64: begin
                  tok.kind  = K_UINT;
                  tok.value = acc_sh;
                end
                TAG_I8: begin
                  tok.kind  = K_INT;
                  tok.value = {{56{acc_sh[7]}}, acc_sh[7:0]};
                end
                TAG_I16: begin
                  tok.kind  = K_INT;
                  tok.value = {{48{acc_sh[15]}}, acc_sh[15:0]};
                end
                TAG_I32: begin
                  tok.kind  = K_INT;
                  tok.value = {{32{acc_sh[31]}}, acc_sh[31:0]};
                end
                TAG_I64: begin
                  tok.kind  = K_INT;
                  tok.value = acc_sh;
                end
                TAG_F32: begin
                  tok.kind  = K_F32;
                  tok.value = {32'd0, acc_sh[31:0]};
                end
                TAG_F64: begin
                  tok.kind  = K_F64;
                  tok.value = acc_sh;
                end
                TAG_BIN8, TAG_BIN16, TAG_BIN32: begin
                  tok_valid  = 1'b0;
                  start_pay  = 1'b1;
                  start_kind = K_BIN;
                  start_len  = acc_sh[31:0];
                end
                TAG_STR8, TAG_STR16, TAG_STR32: begin
                  tok_valid  = 1'b0;
                  start_pay  = 1'b1;
                  start_kind = K_STR;
                  start_len  = acc_sh[31:0];
                end
                TAG_ARR16, TAG_ARR32: begin
                  tok.kind   = K_ARRAY;
                  tok.length = acc_sh[31:0];
                end
                default: begin
                  tok.kind   = K_MAP;
                  tok.length = acc_sh[31:0];
                end
              endcase
            end else if (last_in) begin
              err = 1'b1;
            end
          end
          PH_PAY: begin
            if (payload_left_r > 32'd1 && last_in) begin
              err = 1'b1;
            end else begin
              payload_left_nxt = pay_dec;
              if (pay_dec == 32'd0) begin
                phase_nxt = PH_TAG;
              end
              tok_valid        = 1'b1;
              tok.kind         = K_BYTE;
              tok.value        = {56'd0, b};
              tok.payload_last = (pay_dec == 32'd0);
            end
          end
          default: begin
            // tag byte
            phase_nxt = PH_TAG;
            tok_valid = 1'b1;
            if (b <= 8'h7f) begin
              tok.kind  = K_UINT;
              tok.value = {56'd0, b};
            end else if (b >= 8'he0) begin
              tok.kind  = K_INT;
              tok.value = {56'hff_ffff_ffff_ffff, b};
            end else if (b <= 8'h8f) begin
              tok.kind   = K_MAP;
              tok.length = {28'd0, b[3:0]};
            end else if (b <= 8'h9f) begin
              tok.kind   = K_ARRAY;
              tok.length = {28'd0, b[3:0]};
            end else if (b <= 8'hbf) begin
              tok_valid  = 1'b0;
              start_pay  = 1'b1;
              start_kind = K_STR;
              start_len  = {27'd0, b[4:0]};
            end else if (b == TAG_NIL) begin
              tok.kind = K_NIL;
            end else if (b == TAG_FALSE || b == TAG_TRUE) begin
              tok.kind  = K_BOOL;
              tok.value = {63'd0, b[0]};
            end else if (hdr_n == 4'd0) begin
              // unknown tag drops the rest of the buffer
              tok_valid = 1'b0;
              err       = 1'b1;
              err_drop  = !last_in;
            end else if (last_in) begin
              tok_valid = 1'b0;
              err       = 1'b1;
            end else begin
              tok_valid      = 1'b0;
              tag_nxt        = b;
              bytes_left_nxt = hdr_n;
              acc_nxt        = 64'd0;
              phase_nxt      = PH_HDR;
            end
          end
        endcase

        // str or bin header complete
        if (start_pay) begin
          if (start_len != 32'd0 && last_in) begin
            err = 1'b1;
          end else begin
            payload_left_nxt = start_len;
            phase_nxt        = (start_len != 32'd0) ? PH_PAY : PH_TAG;
            tok_valid        = 1'b1;
            tok.kind         = start_kind;
            tok.length       = start_len;
          end
        end

        // error token overrides whatever was built
        if (err) begin
          phase_nxt    = PH_TAG;
          dropping_nxt = err_drop;
          tok_valid    = 1'b1;
          tok          = '0;
          tok.kind     = K_ERR;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= PH_TAG;
      tag_r          <= 8'd0;
      bytes_left_r   <= 4'd0;
      acc_r          <= 64'd0;
      payload_left_r <= 32'd0;
      dropping_r     <= 1'b0;
    end else begin
      phase_r        <= phase_nxt;
      tag_r          <= tag_nxt;
      bytes_left_r   <= bytes_left_nxt;
      acc_r          <= acc_nxt;
      payload_left_r <= payload_left_nxt;
      dropping_r     <= dropping_nxt;
    end
  end

  // checks
  `MSGTD_ASSERT_IMP(a_hdr_count, clk, rst_n, phase_r == PH_HDR, bytes_left_r != 4'd0)
  `MSGTD_ASSERT_IMP(a_pay_count, clk, rst_n, phase_r == PH_PAY, payload_left_r != 32'd0)
  `MSGTD_ASSERT_IMP(a_drop_phase, clk, rst_n, dropping_r, phase_r == PH_TAG)
  `MSGTD_ASSERT_IMP(a_last_byte, clk, rst_n, tok_valid && tok.payload_last, tok.kind == K_BYTE)
  `MSGTD_ASSERT_NXT(a_drop_hold, clk, rst_n, take && dropping_r && !last_in, dropping_r)

endmodule

/* hw/rtl/msgtd_out_reg.sv */
// result register holding one token until the consumer takes it
module msgtd_out_reg
  import msgtd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        tok_valid,
  input  tok_t        tok,
  output logic        slot_ready,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  out_kind,
  output logic [63:0] out_value,
  output logic [31:0] out_length,
  output logic        out_payload_last
);

  logic valid_r, valid_nxt;
  tok_t tok_r;

  // slot is free when empty or drained this cycle
  assign slot_ready = !valid_r || out_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (slot_ready) begin
      valid_nxt = tok_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (slot_ready && tok_valid) begin
      tok_r <= tok;
    end
  end

  assign out_valid        = valid_r;
  assign out_kind         = tok_r.kind;
  assign out_value        = tok_r.value;
  assign out_length       = tok_r.length;
  assign out_payload_last = tok_r.payload_last;

endmodule

/* hw/rtl/msgpack_token_decoder.sv */
// top level: one encoded byte per cycle unless stalled, at most one token per byte
// an accepted byte is decoded from the input register into the result register
// throughput: one byte per cycle unless stalled, set by input and result registers
// a stalled result register holds back the input stage through the ready chain
// reset (rst_n low, synchronous) empties both registers and returns to tag decode
module msgpack_token_decoder
  import msgtd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_buffer_end,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  out_kind,
  output logic [63:0] out_value,
  output logic [31:0] out_length,
  output logic        out_payload_last
);

  in_item_t in_item;
  in_item_t s1_item;
  logic     s1_valid;
  logic     take;
  logic     slot_ready;
  logic     tok_valid;
  tok_t     tok;

  assign in_item.data_byte  = in_data_byte;
  assign in_item.buffer_end = in_buffer_end;

  // input stage
  msgtd_in_reg u_in_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .s1_valid (s1_valid),
    .s1_item  (s1_item),
    .dn_ready (take)
  );

  // decode
  msgtd_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .s1_valid   (s1_valid),
    .s1_item    (s1_item),
    .slot_ready (slot_ready),
    .take       (take),
    .tok_valid  (tok_valid),
    .tok        (tok)
  );

  // result register
  msgtd_out_reg u_out_reg (
    .clk              (clk),
    .rst_n            (rst_n),
    .tok_valid        (tok_valid),
    .tok              (tok),
    .slot_ready       (slot_ready),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_kind         (out_kind),
    .out_value        (out_value),
    .out_length       (out_length),
    .out_payload_last (out_payload_last)
  );

endmodule

/* dv/msgpack_token_decoder_tb.sv */
// testbench for the messagepack token decoder: token predictor, scoreboard and stimulus
package msgtd_tb_pkg;
  import msgtd_pkg::*;

  // messagepack tag bytes
  localparam logic [7:0] TAG_FIXMAP     = 8'h80;
  localparam logic [7:0] TAG_FIXARRAY   = 8'h90;
  localparam logic [7:0] TAG_FIXSTR     = 8'ha0;
  localparam logic [7:0] TAG_NIL        = 8'hc0;
  localparam logic [7:0] TAG_NEVER_USED = 8'hc1;
  localparam logic [7:0] TAG_FALSE      = 8'hc2;
  localparam logic [7:0] TAG_TRUE       = 8'hc3;
  localparam logic [7:0] TAG_BIN8       = 8'hc4;
  localparam logic [7:0] TAG_BIN16      = 8'hc5;
  localparam logic [7:0] TAG_BIN32      = 8'hc6;
  localparam logic [7:0] TAG_EXT8       = 8'hc7;
  localparam logic [7:0] TAG_FLOAT32    = 8'hca;
  localparam logic [7:0] TAG_FLOAT64    = 8'hcb;
  localparam logic [7:0] TAG_UINT8      = 8'hcc;
  localparam logic [7:0] TAG_UINT16     = 8'hcd;
  localparam logic [7:0] TAG_UINT32     = 8'hce;
  localparam logic [7:0] TAG_UINT64     = 8'hcf;
  localparam logic [7:0] TAG_INT8       = 8'hd0;
  localparam logic [7:0] TAG_INT16      = 8'hd1;
  localparam logic [7:0] TAG_INT32      = 8'hd2;
  localparam logic [7:0] TAG_INT64      = 8'hd3;
  localparam logic [7:0] TAG_FIXEXT1    = 8'hd4;
  localparam logic [7:0] TAG_STR8       = 8'hd9;
  localparam logic [7:0] TAG_STR16      = 8'hda;
  localparam logic [7:0] TAG_STR32      = 8'hdb;
  localparam logic [7:0] TAG_ARRAY16    = 8'hdc;
  localparam logic [7:0] TAG_ARRAY32    = 8'hdd;
  localparam logic [7:0] TAG_MAP16      = 8'hde;
  localparam logic [7:0] TAG_MAP32      = 8'hdf;
  localparam logic [7:0] TAG_NEGFIX     = 8'he0;

  typedef enum logic [1:0] {AWAIT_TAG, IN_HEADER, IN_PAYLOAD} decode_phase_t;

  class token_tracker;
    decode_phase_t phase        = AWAIT_TAG;
    logic [7:0]    tag          = '0;
    logic [3:0]    bytes_left   = '0;
    logic [63:0]   acc          = '0;
    logic [31:0]   payload_left = '0;
    logic          dropping     = 1'b0;
    tok_t          pending_tokens[$];
    int unsigned   fails        = 0;
    int unsigned   seen         = 0;

    task report(string msg);
      fails++;
      if (fails <= 40) $display("mismatch: %s", msg);
    endtask

    function tok_t make_tok(logic [3:0] k, logic [63:0] v, logic [31:0] l, logic p);
      tok_t t;
      t.kind = k;
      t.value = v;
      t.length = l;
      t.payload_last = p;
      return t;
    endfunction

    // error token; keep dropping unless this byte closes the buffer
    function tok_t fault(logic e);
      phase = AWAIT_TAG;
      dropping = !e;
      return make_tok(K_ERR, '0, '0, 1'b0);
    endfunction

    // header bytes that follow a tag
    function int unsigned hdr_len(logic [7:0] t);
      case (t)
        TAG_BIN8, TAG_UINT8, TAG_INT8, TAG_STR8: return 1;
        TAG_BIN16, TAG_UINT16, TAG_INT16, TAG_STR16, TAG_ARRAY16, TAG_MAP16: return 2;
        TAG_BIN32, TAG_FLOAT32, TAG_UINT32, TAG_INT32, TAG_STR32, TAG_ARRAY32,
        TAG_MAP32: return 4;
        TAG_FLOAT64, TAG_UINT64, TAG_INT64: return 8;
        default: return 0;
      endcase
    endfunction

    // str or bin header complete
    function tok_t open_payload(logic [3:0] k, logic [31:0] len, logic e);
      if (len != 0 && e) return fault(1'b1);
      payload_left = len;
      phase = (len != 0) ? IN_PAYLOAD : AWAIT_TAG;
      return make_tok(k, '0, len, 1'b0);
    endfunction

    function tok_t finish_header(logic e);
      phase = AWAIT_TAG;
      case (tag)
        TAG_UINT8, TAG_UINT16, TAG_UINT32, TAG_UINT64: return make_tok(K_UINT, acc, '0, 1'b0);
        TAG_INT8:  return make_tok(K_INT, {{56{acc[7]}}, acc[7:0]}, '0, 1'b0);
        TAG_INT16: return make_tok(K_INT, {{48{acc[15]}}, acc[15:0]}, '0, 1'b0);
        TAG_INT32: return make_tok(K_INT, {{32{acc[31]}}, acc[31:0]}, '0, 1'b0);
        TAG_INT64: return make_tok(K_INT, acc, '0, 1'b0);
        TAG_FLOAT32: return make_tok(K_F32, {32'd0, acc[31:0]}, '0, 1'b0);
        TAG_FLOAT64: return make_tok(K_F64, acc, '0, 1'b0);
        TAG_BIN8, TAG_BIN16, TAG_BIN32: return open_payload(K_BIN, acc[31:0], e);
        TAG_STR8, TAG_STR16, TAG_STR32: return open_payload(K_STR, acc[31:0], e);
        TAG_ARRAY16, TAG_ARRAY32: return make_tok(K_ARRAY, '0, acc[31:0], 1'b0);
        default: return make_tok(K_MAP, '0, acc[31:0], 1'b0);
      endcase
    endfunction

    // advance the decoder by one byte; returns 1 when a token is due
    function bit decode_byte(input logic [7:0] b, input logic e, output tok_t t);
      int unsigned n;
      t = '0;
      if (dropping) begin
        if (e) dropping = 1'b0;
        phase = AWAIT_TAG;
        return 1'b0;
      end
      if (phase == IN_HEADER) begin
        acc = {acc[55:0], b};
        bytes_left = bytes_left - 4'd1;
        if (bytes_left == 4'd0) begin
          t = finish_header(e);
          return 1'b1;
        end
        if (e) begin
          t = fault(1'b1);
          return 1'b1;
        end
        return 1'b0;
      end
      if (phase == IN_PAYLOAD) begin
        if (payload_left > 1 && e) begin
          t = fault(1'b1);
          return 1'b1;
        end
        payload_left = payload_left - 1;
        if (payload_left == 0) phase = AWAIT_TAG;
        t = make_tok(K_BYTE, {56'd0, b}, '0, payload_left == 0);
        return 1'b1;
      end
      // tag byte
      phase = AWAIT_TAG;
      if (b < TAG_FIXMAP) t = make_tok(K_UINT, {56'd0, b}, '0, 1'b0);
      else if (b >= TAG_NEGFIX) t = make_tok(K_INT, {{56{1'b1}}, b}, '0, 1'b0);
      else if (b < TAG_FIXARRAY) t = make_tok(K_MAP, '0, {28'd0, b[3:0]}, 1'b0);
      else if (b < TAG_FIXSTR) t = make_tok(K_ARRAY, '0, {28'd0, b[3:0]}, 1'b0);
      else if (b < TAG_NIL) t = open_payload(K_STR, {27'd0, b[4:0]}, e);
      else if (b == TAG_NIL) t = make_tok(K_NIL, '0, '0, 1'b0);
      else if (b == TAG_FALSE || b == TAG_TRUE) t = make_tok(K_BOOL, {63'd0, b[0]}, '0, 1'b0);
      else begin
        n = hdr_len(b);
        if (n == 0) t = fault(e);
        else if (e) t = fault(1'b1);
        else begin
          tag = b;
          bytes_left = n[3:0];
          acc = '0;
          phase = IN_HEADER;
          return 1'b0;
        end
      end
      return 1'b1;
    endfunction

    // note an accepted request
    function void note_request(logic [7:0] b, logic e);
      tok_t t;
      if (decode_byte(b, e, t)) pending_tokens.push_back(t);
    endfunction

    function int unsigned pending();
      return pending_tokens.size();
    endfunction

    // compare one accepted token with the oldest one due
    task check_token(tok_t got);
      tok_t want;
      seen++;
      if (pending_tokens.size() == 0) begin
        report($sformatf("token %0d: kind %0d value %h length %h last %b with none due",
                         seen, got.kind, got.value, got.length, got.payload_last));
      end else begin
        want = pending_tokens.pop_front();
        if (got.kind !== want.kind || got.value !== want.value ||
            got.length !== want.length || got.payload_last !== want.payload_last)
          report($sformatf("token %0d: got %0d/%h/%h/%b want %0d/%h/%h/%b", seen,
                           got.kind, got.value, got.length, got.payload_last,
                           want.kind, want.value, want.length, want.payload_last));
      end
    endtask

    // tokens still due at the end of the run
    task close();
      tok_t want;
      while (pending_tokens.size() != 0) begin
        want = pending_tokens.pop_front();
        report($sformatf("token kind %0d value %h length %h never arrived",
                         want.kind, want.value, want.length));
      end
    endtask
  endclass

endpackage

module msgpack_token_decoder_tb;
  import msgtd_pkg::*;
  import msgtd_tb_pkg::*;

  localparam logic BUF_MORE = 1'b0;
  localparam logic BUF_LAST = 1'b1;
  localparam int   SETTLE_CYCLES = 8;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_data_byte = '0;
  logic        in_buffer_end = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [3:0]  out_kind;
  logic [63:0] out_value;
  logic [31:0] out_length;
  logic        out_payload_last;

  token_tracker track = new();
  int unsigned  idle_pct = 0;
  int unsigned  stall_pct = 0;
  int unsigned  hold_cycles = 0;
  int unsigned  sent = 0;
  logic [7:0]   frame_bytes[$];

  msgpack_token_decoder dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data_byte(in_data_byte),
    .in_buffer_end(in_buffer_end),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_kind(out_kind),
    .out_value(out_value),
    .out_length(out_length),
    .out_payload_last(out_payload_last)
  );

  always #4 clk = ~clk;

  // receiver: long hold-off when asked, random stalls otherwise
  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      out_ready <= 1'b0;
      hold_cycles--;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // check each accepted token
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      track.check_token({out_kind, out_value, out_length, out_payload_last});
  end

  // offer one request, idling first at random
  task automatic send_byte(input logic [7:0] b, input logic e);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data_byte <= b;
    in_buffer_end <= e;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    track.note_request(b, e);
    sent++;
  endtask

  // sender pause until every token due has come
  task automatic wait_drained();
    int unsigned n;
    n = 0;
    in_valid <= 1'b0;
    while (track.pending() != 0 && n < 20000) begin
      @(posedge clk);
      n++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [63:0] rand64();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // mostly short lengths, now and then a longer one
  function automatic int unsigned short_len(int unsigned cap);
    if ($urandom_range(0, 7) == 0) return $urandom_range(5, cap);
    return $urandom_range(0, 4);
  endfunction

  function automatic void put_be(logic [63:0] v, int unsigned n);
    for (int i = n - 1; i >= 0; i--) frame_bytes.push_back(v[8*i +: 8]);
  endfunction

  function automatic void put_payload(int unsigned len);
    repeat (len) frame_bytes.push_back(8'($urandom));
  endfunction

  function automatic logic [7:0] unknown_tag();
    int unsigned k;
    k = $urandom_range(0, 8);
    if (k == 0) return TAG_NEVER_USED;
    if (k <= 3) return TAG_EXT8 + 8'(k - 1);
    return TAG_FIXEXT1 + 8'(k - 4);
  endfunction

  // append one well-formed token with random content
  function automatic void add_token();
    int unsigned k;
    int unsigned len;
    k = $urandom_range(0, 3);
    case ($urandom_range(0, 10))
      0: frame_bytes.push_back(8'($urandom_range(0, 127)));
      1: frame_bytes.push_back(TAG_NEGFIX | 8'($urandom_range(0, 31)));
      2: frame_bytes.push_back(TAG_FIXMAP | 8'($urandom_range(0, 15)));
      3: frame_bytes.push_back(TAG_FIXARRAY | 8'($urandom_range(0, 15)));
      4: begin
        len = short_len(31);
        frame_bytes.push_back(TAG_FIXSTR | 8'(len));
        put_payload(len);
      end
      5: begin
        if (k == 0) frame_bytes.push_back(TAG_NIL);
        else frame_bytes.push_back(k[0] ? TAG_TRUE : TAG_FALSE);
      end
      6: begin
        frame_bytes.push_back(TAG_UINT8 + 8'(k));
        put_be(rand64(), 1 << k);
      end
      7: begin
        frame_bytes.push_back(TAG_INT8 + 8'(k));
        put_be(rand64(), 1 << k);
      end
      8: begin
        frame_bytes.push_back(k[0] ? TAG_FLOAT64 : TAG_FLOAT32);
        put_be(rand64(), k[0] ? 8 : 4);
      end
      9: begin
        len = short_len(40);
        k = $urandom_range(0, 2);
        frame_bytes.push_back(($urandom_range(0, 1) ? TAG_STR8 : TAG_BIN8) + 8'(k));
        put_be(64'(len), 1 << k);
        put_payload(len);
      end
      default: begin
        k = $urandom_range(0, 1);
        frame_bytes.push_back(($urandom_range(0, 1) ? TAG_MAP16 : TAG_ARRAY16) + 8'(k));
        put_be(rand64(), 2 << k);
      end
    endcase
  endfunction

  // one buffer: mostly well-formed, some cut short, some with a bad tag, some noise
  task automatic send_frame();
    int unsigned shape;
    int unsigned n;
    frame_bytes.delete();
    shape = $urandom_range(0, 19);
    if (shape == 0) begin
      repeat ($urandom_range(1, 8)) frame_bytes.push_back(8'($urandom));
    end else begin
      repeat ($urandom_range(1, 5)) add_token();
      if (shape == 1 && frame_bytes.size() > 1)
        frame_bytes = frame_bytes[0:$urandom_range(0, frame_bytes.size() - 2)];
      else if (shape == 2)
        frame_bytes.insert($urandom_range(0, frame_bytes.size()), unknown_tag());
    end
    n = frame_bytes.size();
    for (int i = 0; i < n; i++) send_byte(frame_bytes[i], i == n - 1);
  endtask

  task automatic send_random(int unsigned count);
    int unsigned stop;
    stop = sent + count;
    while (sent < stop) send_frame();
  endtask

  // extremes, every token class but the floats, error paths for cut buffers and a bad tag
  task automatic send_directed();
    send_byte(8'h00, BUF_MORE);
    send_byte(8'h7f, BUF_MORE);
    send_byte(TAG_NEGFIX, BUF_MORE);
    send_byte(8'hff, BUF_MORE);
    send_byte(TAG_FIXMAP | 8'h0f, BUF_MORE);
    send_byte(TAG_FIXARRAY, BUF_MORE);
    // empty str then a one-byte str
    send_byte(TAG_FIXSTR, BUF_MORE);
    send_byte(TAG_FIXSTR | 8'h01, BUF_MORE);
    send_byte(8'h41, BUF_MORE);
    send_byte(TAG_NIL, BUF_MORE);
    send_byte(TAG_TRUE, BUF_MORE);
    send_byte(TAG_INT8, BUF_MORE);
    send_byte(8'h80, BUF_MORE);
    // array32 count wider than 16 bits
    send_byte(TAG_ARRAY32, BUF_MORE);
    send_byte(8'h80, BUF_MORE);
    send_byte(8'h00, BUF_MORE);
    send_byte(8'h00, BUF_MORE);
    send_byte(8'h01, BUF_MORE);
    // buffer ends inside a header
    send_byte(TAG_UINT16, BUF_MORE);
    send_byte(8'h12, BUF_LAST);
    // str header with a length closes the buffer
    send_byte(TAG_FIXSTR | 8'h02, BUF_LAST);
    // buffer ends inside a payload
    send_byte(TAG_BIN8, BUF_MORE);
    send_byte(8'h02, BUF_MORE);
    send_byte(8'h5a, BUF_LAST);
    // unknown tag, rest of the buffer dropped
    send_byte(TAG_NEVER_USED, BUF_MORE);
    send_byte(8'h33, BUF_MORE);
    send_byte(8'h44, BUF_LAST);
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    send_directed();
    wait_drained();

    // no idling, then a long receiver hold-off while requests keep coming
    send_random(450);
    hold_cycles = 200;
    send_random(60);
    wait_drained();

    // sender idle
    idle_pct = 47;
    send_random(460);
    wait_drained();

    // receiver stalling
    idle_pct = 0;
    stall_pct = 47;
    send_random(460);
    wait_drained();

    // both sides idle
    idle_pct = 22;
    stall_pct = 22;
    send_random(460);
    wait_drained();

    track.close();
    if (track.fails == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // run limit
  initial begin
    #2000000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
